// ----- rtl/scfp_pkg.sv -----
// Shared constants and types for the serial command frame parser.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package scfp_pkg;

   // payload store geometry
   localparam int PAYLOAD_BYTES = 32;
   localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
   localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

   // framing bytes
   localparam logic [7:0] CH_START    = 8'h41;  // 'A'
   localparam logic [7:0] CH_REQUEST  = 8'h73;  // 's'
   localparam logic [7:0] CH_CONTROL  = 8'h63;  // 'c'
   localparam logic [7:0] CH_FOOT_P   = 8'h70;  // 'p'
   localparam logic [7:0] CH_FOOT_K   = 8'h6B;  // 'k'

   // request keywords as little-endian words of store bytes 0..3
   localparam logic [31:0] KEY_PING = 32'h676E_6950;  // "Ping"
   localparam logic [31:0] KEY_TIME = 32'h656D_6954;  // "Time"

   // payload offsets of the control words
   localparam int OFS_X  = 0;
   localparam int OFS_Y  = 4;
   localparam int OFS_RZ = 20;

   // event codes
   localparam logic [1:0] EV_PING = 2'd0;
   localparam logic [1:0] EV_TIME = 2'd1;
   localparam logic [1:0] EV_CTRL = 2'd2;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] word_x;
      logic [31:0] word_y;
      logic [31:0] word_rz;
   } rsp_type;

endpackage

// ----- rtl/scfp_parser.sv -----
// Frame parser: phase sequencer, running checksum and payload store.
// Depends on scfp_pkg; emits one event on each passing decodable frame.
module scfp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_accept,
   input  logic [7:0]         rx_byte,
   output logic               hit_valid,
   output scfp_pkg::rsp_type  hit
);

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_TYPE   = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_CHK    = 3'd4;
   localparam logic [2:0] PH_FOOT_P = 3'd5;
   localparam logic [2:0] PH_FOOT_K = 3'd6;

   logic [2:0]                   phase_ff, phase_in;
   logic                         is_ctrl_ff, is_ctrl_in;
   logic [scfp_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [scfp_pkg::LEN_W-1:0]   pos_ff, pos_in;
   logic [scfp_pkg::LEN_W-1:0]   pos_inc;
   logic [7:0]                   xor_ff, xor_in;
   logic [7:0]                   chk_ff, chk_in;
   logic [7:0]                   store_ff [scfp_pkg::PAYLOAD_BYTES];
   logic                         store_we;
   logic [31:0]                  w_x, w_y, w_rz;
   logic                         frame_ok;

   assign pos_inc = pos_ff + scfp_pkg::LEN_W'(1);

   assign w_x  = {store_ff[scfp_pkg::OFS_X+3],  store_ff[scfp_pkg::OFS_X+2],
                  store_ff[scfp_pkg::OFS_X+1],  store_ff[scfp_pkg::OFS_X]};
   assign w_y  = {store_ff[scfp_pkg::OFS_Y+3],  store_ff[scfp_pkg::OFS_Y+2],
                  store_ff[scfp_pkg::OFS_Y+1],  store_ff[scfp_pkg::OFS_Y]};
   assign w_rz = {store_ff[scfp_pkg::OFS_RZ+3], store_ff[scfp_pkg::OFS_RZ+2],
                  store_ff[scfp_pkg::OFS_RZ+1], store_ff[scfp_pkg::OFS_RZ]};

   always_comb begin
      phase_in   = phase_ff;
      is_ctrl_in = is_ctrl_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      chk_in     = chk_ff;
      store_we   = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == scfp_pkg::CH_START) phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            if (rx_byte == scfp_pkg::CH_REQUEST || rx_byte == scfp_pkg::CH_CONTROL) begin
               is_ctrl_in = (rx_byte == scfp_pkg::CH_CONTROL);
               phase_in   = PH_LEN;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            if (rx_byte > 8'(scfp_pkg::PAYLOAD_BYTES)) begin
               phase_in = PH_HUNT;
            end else begin
               len_in   = scfp_pkg::LEN_W'(rx_byte);
               pos_in   = '0;
               xor_in   = '0;
               phase_in = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
            end
         end
         PH_DATA: begin
            store_we = (pos_ff < scfp_pkg::LEN_W'(scfp_pkg::PAYLOAD_BYTES));
            xor_in   = xor_ff ^ rx_byte;
            pos_in   = pos_inc;
            if (pos_inc >= len_ff) phase_in = PH_CHK;
         end
         PH_CHK: begin
            chk_in   = rx_byte;
            phase_in = PH_FOOT_P;
         end
         PH_FOOT_P: begin
            phase_in = (rx_byte == scfp_pkg::CH_FOOT_P) ? PH_FOOT_K : PH_HUNT;
         end
         PH_FOOT_K: begin
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // decode the event on the closing footer byte
   assign frame_ok = (phase_ff == PH_FOOT_K) && (rx_byte == scfp_pkg::CH_FOOT_K)
                     && (chk_ff == xor_ff);

   always_comb begin
      hit.event_kind = scfp_pkg::EV_CTRL;
      hit.word_x     = '0;
      hit.word_y     = '0;
      hit.word_rz    = '0;
      hit_valid      = 1'b0;
      if (is_ctrl_ff) begin
         hit.word_x  = w_x;
         hit.word_y  = w_y;
         hit.word_rz = w_rz;
         hit_valid   = byte_accept && frame_ok;
      end else if (w_x == scfp_pkg::KEY_PING) begin
         hit.event_kind = scfp_pkg::EV_PING;
         hit_valid      = byte_accept && frame_ok;
      end else if (w_x == scfp_pkg::KEY_TIME) begin
         hit.event_kind = scfp_pkg::EV_TIME;
         hit_valid      = byte_accept && frame_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         is_ctrl_ff <= 1'b0;
         len_ff     <= '0;
         pos_ff     <= '0;
         xor_ff     <= '0;
         chk_ff     <= '0;
         for (int i = 0; i < scfp_pkg::PAYLOAD_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else if (byte_accept) begin
         phase_ff   <= phase_in;
         is_ctrl_ff <= is_ctrl_in;
         len_ff     <= len_in;
         pos_ff     <= pos_in;
         xor_ff     <= xor_in;
         chk_ff     <= chk_in;
         if (store_we) store_ff[pos_ff[scfp_pkg::IDX_W-1:0]] <= rx_byte;
      end
   end

endmodule

// ----- rtl/scfp_out_stage.sv -----
// Result register with a one-entry skid buffer behind it.
// Depends on scfp_pkg for the result word type.
module scfp_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               hit_valid,
   input  scfp_pkg::rsp_type  hit,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output scfp_pkg::rsp_type  out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   scfp_pkg::rsp_type out_data_ff, out_data_in;
   scfp_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              out_free;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_free  = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         // refill from the skid first, then from the parser
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = hit_valid;
            out_data_in  = hit;
         end
      end else if (hit_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- rtl/serial_command_frame_parser_top.sv -----
// Top level of the serial command frame parser.
// Depends on scfp_pkg, scfp_parser and scfp_out_stage.
//
// Takes one received byte per word on the req_ channel and recognizes frames
// of the form 'A', type ('s' request or 'c' control), length, payload, XOR
// checksum, 'p', 'k'. A passing control frame yields event kind 2 with three
// little-endian words from payload offsets 0, 4 and 20; a passing request
// frame whose payload starts "Ping" or "Time" yields kind 0 or 1 with zero
// words; anything else yields nothing. Lengths above 32 abandon the frame.
// Payload bytes beyond a short frame's length keep earlier contents (zero
// after reset). Rate: one byte per cycle while req_ready is high; each byte
// is a single pass through the phase sequencer. Results are registered
// before rsp_ shows them. A result register plus one skid entry part the
// two sides, so req_ready drops only while both hold results. Reset is
// synchronous; no clearing pass is needed.
module serial_command_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_word_x,
   output logic [31:0] rsp_word_y,
   output logic [31:0] rsp_word_rz
);

   logic              byte_accept;
   logic              hit_valid;
   scfp_pkg::rsp_type hit;
   scfp_pkg::rsp_type rsp_data;

   // advance the parser only on an accepted word
   assign byte_accept = req_valid && req_ready;

   scfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .hit_valid   (hit_valid),
      .hit         (hit)
   );

   scfp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .hit_valid (hit_valid),
      .hit       (hit),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_event_kind = rsp_data.event_kind;
   assign rsp_word_x     = rsp_data.word_x;
   assign rsp_word_y     = rsp_data.word_y;
   assign rsp_word_rz    = rsp_data.word_rz;

endmodule

// ----- tb/scfp_frame_checker.sv -----
`timescale 1ns / 100ps
// Frame checker for the serial command frame parser: predicts events from accepted bytes.
// Depends on scfp_pkg; the testbench top instantiates it beside the parser.
module scfp_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_event_kind,
   input  logic [31:0] rsp_word_x,
   input  logic [31:0] rsp_word_y,
   input  logic [31:0] rsp_word_rz,
   output int          mismatch_count,
   output int          events_awaited,
   output int          events_seen
);
   import scfp_pkg::*;

   typedef enum logic [2:0] {
      P_HUNT, P_TYPE, P_LEN, P_DATA, P_CHK, P_FOOT_P, P_FOOT_K
   } parse_phase_type;

   parse_phase_type phase;
   logic         is_control;
   int           frame_len;
   int           data_pos;
   logic [7:0]   xor_acc;
   logic [7:0]   chk_byte;
   logic [7:0]   shadow_store [PAYLOAD_BYTES];
   rsp_type      expected_events [$];
   rsp_type      oldest;
   int           errors  = 0;
   int           checked = 0;

   function automatic logic [31:0] store_word(int base);
      return {shadow_store[base + 3], shadow_store[base + 2],
              shadow_store[base + 1], shadow_store[base]};
   endfunction

   // advance the shadow parser by one byte; queue an event when a frame passes
   task automatic advance_parser(input logic [7:0] b);
      rsp_type ev;
      ev = '0;
      case (phase)
         P_HUNT: begin
            if (b == CH_START) phase = P_TYPE;
         end
         P_TYPE: begin
            if (b == CH_REQUEST || b == CH_CONTROL) begin
               is_control = (b == CH_CONTROL);
               phase      = P_LEN;
            end else begin
               phase = P_HUNT;
            end
         end
         P_LEN: begin
            if (int'(b) > PAYLOAD_BYTES) begin
               phase = P_HUNT;
            end else begin
               frame_len = int'(b);
               data_pos  = 0;
               xor_acc   = 8'h00;
               phase     = (b == 8'h00) ? P_CHK : P_DATA;
            end
         end
         P_DATA: begin
            shadow_store[data_pos] = b;
            xor_acc  = xor_acc ^ b;
            data_pos = data_pos + 1;
            if (data_pos >= frame_len) phase = P_CHK;
         end
         P_CHK: begin
            chk_byte = b;
            phase    = P_FOOT_P;
         end
         P_FOOT_P: begin
            phase = (b == CH_FOOT_P) ? P_FOOT_K : P_HUNT;
         end
         default: begin
            phase = P_HUNT;
            if (b == CH_FOOT_K && chk_byte == xor_acc) begin
               if (is_control) begin
                  ev.event_kind = EV_CTRL;
                  ev.word_x     = store_word(OFS_X);
                  ev.word_y     = store_word(OFS_Y);
                  ev.word_rz    = store_word(OFS_RZ);
                  expected_events.push_back(ev);
               end else if (store_word(0) == KEY_PING) begin
                  ev.event_kind = EV_PING;
                  expected_events.push_back(ev);
               end else if (store_word(0) == KEY_TIME) begin
                  ev.event_kind = EV_TIME;
                  expected_events.push_back(ev);
               end
            end
         end
      endcase
   endtask

   task automatic flag_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, label, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase      = P_HUNT;
         is_control = 1'b0;
         frame_len  = 0;
         data_pos   = 0;
         xor_acc    = 8'h00;
         chk_byte   = 8'h00;
         for (int i = 0; i < PAYLOAD_BYTES; i++) shadow_store[i] = 8'h00;
         expected_events.delete();
      end else begin
         // check before predicting: an event never leaves in the cycle its 'k' arrives
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event expected none got kind %0d x %h y %h rz %h",
                        $time, rsp_event_kind, rsp_word_x, rsp_word_y, rsp_word_rz);
               errors++;
            end else begin
               oldest = expected_events.pop_front();
               checked++;
               flag_field("event_kind", 32'(oldest.event_kind), 32'(rsp_event_kind));
               flag_field("word_x", oldest.word_x, rsp_word_x);
               flag_field("word_y", oldest.word_y, rsp_word_y);
               flag_field("word_rz", oldest.word_rz, rsp_word_rz);
            end
         end
         if (req_valid && req_ready) advance_parser(req_rx_byte);
      end
      mismatch_count <= errors;
      events_awaited <= expected_events.size();
      events_seen    <= checked;
   end

endmodule

// ----- tb/serial_command_frame_parser_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the serial command frame parser: byte stimulus, idle mixes and verdict.
// Depends on scfp_pkg, serial_command_frame_parser_top and scfp_frame_checker.
module serial_command_frame_parser_top_tb;
   import scfp_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RUN_LIMIT    = 400000;  // cycles; far above the slowest correct run
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
   localparam int BYTE_TARGET  = 850;     // random bytes over all idle mixes
   localparam int SETTLE       = 20;      // cycles after the last event

   typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_P, FR_BAD_K} framing_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_ready   = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_event_kind;
   logic [31:0] rsp_word_x;
   logic [31:0] rsp_word_y;
   logic [31:0] rsp_word_rz;

   int mismatch_count;
   int events_awaited;
   int events_seen;

   // idle mix, written only by the stimulus process
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // hold-off requests; the receiver process serves them one at a time
   int holds_asked    = 0;
   int holds_served   = 0;

   int bytes_sent   = 0;
   int frames_built = 0;
   int cycle_count  = 0;

   logic [7:0] payload_q [$];
   logic [7:0] tx_q [$];

   always #(HALF_PERIOD) clock = ~clock;

   serial_command_frame_parser_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_word_x     (rsp_word_x),
      .rsp_word_y     (rsp_word_y),
      .rsp_word_rz    (rsp_word_rz)
   );

   scfp_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_word_x     (rsp_word_x),
      .rsp_word_y     (rsp_word_y),
      .rsp_word_rz    (rsp_word_rz),
      .mismatch_count (mismatch_count),
      .events_awaited (events_awaited),
      .events_seen    (events_seen)
   );

   // Watchdog: drop the run if it never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: stall at the current rate, or hold off for a long stretch on request.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offer one byte, idling at random first; return in the cycle it is accepted.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_queued();
      while (tx_q.size() > 0) send_byte(tx_q.pop_front());
   endtask

   // Lower valid and wait until every predicted event has come back.
   task automatic drain_events();
      req_valid <= 1'b0;
      @(posedge clock);
      while (events_awaited != 0) @(posedge clock);
   endtask

   // Fill the payload; optionally lead with a keyword word (little endian).
   function automatic void fill_payload(int len, logic [31:0] lead, bit use_lead);
      payload_q.delete();
      for (int k = 0; k < len; k++) begin
         if (use_lead && k < 4) payload_q.push_back(lead[8*k +: 8]);
         else payload_q.push_back(8'($urandom_range(255)));
      end
   endfunction

   // Wrap the payload in a frame; corrupt the checksum or a footer byte on request.
   function automatic void frame_to_tx(logic [7:0] kind_b, framing_type how);
      logic [7:0] sum;
      sum = 8'h00;
      foreach (payload_q[k]) sum = sum ^ payload_q[k];
      tx_q.push_back(CH_START);
      tx_q.push_back(kind_b);
      tx_q.push_back(8'(payload_q.size()));
      foreach (payload_q[k]) tx_q.push_back(payload_q[k]);
      tx_q.push_back((how == FR_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
      tx_q.push_back((how == FR_BAD_P) ? CH_FOOT_P ^ 8'($urandom_range(1, 255)) : CH_FOOT_P);
      tx_q.push_back((how == FR_BAD_K) ? CH_FOOT_K ^ 8'($urandom_range(1, 255)) : CH_FOOT_K);
      frames_built++;
   endfunction

   // Queue one random chunk of traffic: mostly well-formed frames, some broken, some noise.
   task automatic queue_random_traffic();
      int         pick;
      int         len;
      logic [7:0] t;
      pick = $urandom_range(99);
      if (pick < 35) begin
         // control frame; mostly short, sometimes long enough to cover the rz word
         len = ($urandom_range(9) < 7) ? $urandom_range(8) : $urandom_range(20, PAYLOAD_BYTES);
         fill_payload(len, 32'h0, 1'b0);
         frame_to_tx(CH_CONTROL, FR_GOOD);
      end else if (pick < 50) begin
         fill_payload($urandom_range(4, 12), KEY_PING, 1'b1);
         frame_to_tx(CH_REQUEST, FR_GOOD);
      end else if (pick < 62) begin
         fill_payload($urandom_range(4, 12), KEY_TIME, 1'b1);
         frame_to_tx(CH_REQUEST, FR_GOOD);
      end else if (pick < 70) begin
         // unknown request: random keyword, normally no event
         fill_payload($urandom_range(1, 8), 32'h0, 1'b0);
         frame_to_tx(CH_REQUEST, FR_GOOD);
      end else if (pick < 76) begin
         // short request: the keyword comes partly from earlier store contents
         fill_payload($urandom_range(0, 3), 32'h0, 1'b0);
         frame_to_tx(CH_REQUEST, FR_GOOD);
      end else if (pick < 82) begin
         fill_payload($urandom_range(0, 8), KEY_PING, 1'($urandom_range(1)));
         frame_to_tx($urandom_range(1) ? CH_CONTROL : CH_REQUEST,
                     framing_type'($urandom_range(FR_BAD_SUM, FR_BAD_K)));
      end else if (pick < 88) begin
         // bad type byte, sometimes a second start byte
         if ($urandom_range(3) == 0) begin
            t = CH_START;
         end else begin
            do t = 8'($urandom_range(255)); while (t == CH_REQUEST || t == CH_CONTROL);
         end
         tx_q.push_back(CH_START);
         tx_q.push_back(t);
      end else if (pick < 92) begin
         // oversized length abandons the frame
         tx_q.push_back(CH_START);
         tx_q.push_back($urandom_range(1) ? CH_CONTROL : CH_REQUEST);
         tx_q.push_back(8'($urandom_range(PAYLOAD_BYTES + 1, 255)));
      end else if (pick < 96) begin
         // truncated frame; following bytes get swallowed as its payload
         len = $urandom_range(1, 8);
         tx_q.push_back(CH_START);
         tx_q.push_back(CH_CONTROL);
         tx_q.push_back(8'(len));
         repeat ($urandom_range(0, len - 1)) tx_q.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int mix_start;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: bad type byte that is itself a start byte, then a stray 's'
      tx_q.push_back(CH_START);
      tx_q.push_back(CH_START);
      tx_q.push_back(CH_REQUEST);
      // ping, then an empty request that reuses the stored keyword
      fill_payload(4, KEY_PING, 1'b1);
      frame_to_tx(CH_REQUEST, FR_GOOD);
      fill_payload(0, 32'h0, 1'b0);
      frame_to_tx(CH_REQUEST, FR_GOOD);
      // largest length byte, then an empty control frame reading leftovers
      tx_q.push_back(CH_START);
      tx_q.push_back(CH_CONTROL);
      tx_q.push_back(8'hFF);
      fill_payload(0, 32'h0, 1'b0);
      frame_to_tx(CH_CONTROL, FR_GOOD);
      send_queued();
      drain_events();

      // Random traffic over four idle mixes; drain between mixes.
      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         mix_start = bytes_sent;
         if (mix == 0) begin
            // hold the receiver off while back-to-back control frames fill the block
            holds_asked++;
            repeat (10) begin
               fill_payload(0, 32'h0, 1'b0);
               frame_to_tx(CH_CONTROL, FR_GOOD);
            end
            send_queued();
         end
         while (bytes_sent - mix_start < BYTE_TARGET / 4) begin
            queue_random_traffic();
            send_queued();
         end
         drain_events();
      end

      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d bytes in %0d frames plus noise over four idle mixes and a hold-off;",
               bytes_sent, frames_built);
      $display("checked %0d events.", events_seen);
      if (mismatch_count == 0 && events_awaited == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/scfp_pkg.sv
rtl/scfp_parser.sv
rtl/scfp_out_stage.sv
rtl/serial_command_frame_parser_top.sv
tb/scfp_frame_checker.sv
tb/serial_command_frame_parser_top_tb.sv
